@@ hdl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers; they expand to nothing when SYNTH is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checks that ante implies cons in the same cycle.
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
// Checks that ante implies cons in the next cycle.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(name, clk, rst_n, ante, cons)
`define ASSERT_NEXT(name, clk, rst_n, ante, cons)
`endif
`endif

@@ hdl/otas_pkg.sv @@
// ---------------------------------------------------------------------------
// Obstacle to audio source package
// Shared types, command codes and constant tables.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
package otas_pkg;

  // Configuration register indexes.
  localparam logic [1:0] CFG_MIN_MASS       = 2'd0;
  localparam logic [1:0] CFG_MAX_DEPTH      = 2'd1;
  localparam logic [1:0] CFG_INV_PROX_DECAY = 2'd2;
  localparam logic [1:0] CFG_INV_REF_MASS   = 2'd3;

  // 0.01 m in Q16.16.
  localparam logic signed [31:0] DEPTH_FLOOR = 32'sd655;
  // ln(2) in Q16.16.
  localparam logic [19:0] LN2_Q16 = 20'd45426;
  // 21 * ln(2): at or above this exponent the proximity is zero.
  localparam logic [47:0] PROX_LIMIT = 48'd953946;
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [16:0] ONE_Q16 = 17'd65536;
  localparam int unsigned CORDIC_STEPS = 16;

  localparam logic [16:0] ATAN_TAB [CORDIC_STEPS] = '{
    17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
    17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2
  };

  // ceil(2^33 / k) for the divisors that are not powers of two.
  localparam logic [31:0] RECIP_M [9] = '{
    32'd0, 32'd0, 32'd0, 32'd2863311531, 32'd0,
    32'd1717986919, 32'd1431655766, 32'd1227133514, 32'd0
  };

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_POSE_WR,
    OP_LOAD,
    OP_XF_MUL,
    OP_XF_ACC,
    OP_CONF_MUL,
    OP_PROX_MUL,
    OP_PROX_A,
    OP_DIV_STEP,
    OP_HORNER_MUL,
    OP_HORNER_DIV,
    OP_HORNER_SUB,
    OP_PROX_FIN,
    OP_CORDIC_INIT,
    OP_CORDIC_STEP,
    OP_EMIT,
    OP_FINISH
  } op_e;

  typedef struct packed {
    op_e        op;
    logic [1:0] row;
    logic [1:0] col;
    logic [3:0] k;
    logic [3:0] step;
  } cmd_t;

  typedef struct packed {
    logic qualify;
    logic depth_ok;
    logic big;
    logic rem_ge;
  } stat_t;

  function automatic logic k_pow2(input logic [3:0] k);
    return (k == 4'd1) || (k == 4'd2) || (k == 4'd4) || (k == 4'd8);
  endfunction

  function automatic logic [1:0] k_log2(input logic [3:0] k);
    logic [1:0] r;
    case (k)
      4'd2:    r = 2'd1;
      4'd4:    r = 2'd2;
      4'd8:    r = 2'd3;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

@@ hdl/otas_dp.sv @@
// ---------------------------------------------------------------------------
// Obstacle to audio source datapath
// Pose store, configuration, shared multiplier, divider, exponent and CORDIC.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module otas_dp #(
  parameter int MAX_SOURCES = 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_addr_i,
  input  logic [31:0]         cfg_wdata_i,
  input  logic [3:0]          pose_index_i,
  input  logic signed [31:0]  pose_value_i,
  input  logic                cluster_active_i,
  input  logic [31:0]         cluster_mass_i,
  input  logic signed [31:0]  cluster_x_i,
  input  logic signed [31:0]  cluster_y_i,
  input  logic signed [31:0]  cluster_z_i,
  input  logic                last_cluster_i,
  input  otas_pkg::cmd_t      cmd_i,
  output otas_pkg::stat_t     stat_o,
  output logic signed [15:0]  azimuth_o,
  output logic signed [15:0]  elevation_o,
  output logic [16:0]         proximity_o,
  output logic [16:0]         confidence_o,
  output logic [2:0]          source_slot_o
);
  import otas_pkg::*;

  localparam int CNT_W = $clog2(MAX_SOURCES + 1);

  logic [31:0] min_mass_q, inv_prox_q, inv_ref_q;
  logic [30:0] max_depth_q;
  logic signed [31:0] pose_q [12];
  logic [CNT_W-1:0] emit_q;

  logic act_q, last_q;
  logic [31:0] mass_q;
  logic signed [31:0] cx_q, cy_q, cz_q, xc_q, yc_q, zc_q;
  logic signed [65:0] prod_q;
  logic signed [51:0] acc_q;
  logic [19:0] r_q;
  logic [4:0] n_q;
  logic big_q;
  logic [30:0] s_q;
  logic [16:0] conf_q, prox_q;
  logic signed [35:0] ax_q, ay_q, ex_q, ey_q;
  logic signed [19:0] aang_q, eang_q;

  logic signed [32:0] mul_a, mul_b;
  logic mul_en;
  logic [3:0] pidx, tidx;
  logic signed [31:0] coord;
  logic signed [51:0] acc_base, acc_d;
  logic signed [31:0] sat_d;
  logic [29:0] hq;
  logic [47:0] a_val;
  logic [34:0] prox_sum;
  logic [5:0] sh_rnd, sh_out;
  logic signed [35:0] ax_sh, ay_sh, ex_sh, ey_sh;
  logic signed [19:0] atan_s, az_r, el_r;

  assign pidx = 4'({2'b0, cmd_i.row} * 4'd3) + {2'b0, cmd_i.col};
  assign tidx = 4'd9 + {2'b0, cmd_i.row};
  assign hq   = prod_q[59:30];
  assign a_val = prod_q[63:16];

  always_comb begin
    case (cmd_i.col)
      2'd0:    coord = cx_q;
      2'd1:    coord = cy_q;
      default: coord = cz_q;
    endcase
  end

  always_comb begin
    mul_a  = '0;
    mul_b  = '0;
    mul_en = 1'b1;
    case (cmd_i.op)
      OP_XF_MUL: begin
        mul_a = {pose_q[pidx][31], pose_q[pidx]};
        mul_b = {coord[31], coord};
      end
      OP_CONF_MUL: begin
        mul_a = {1'b0, mass_q};
        mul_b = {1'b0, inv_ref_q};
      end
      OP_PROX_MUL: begin
        mul_a = {1'b0, zc_q};
        mul_b = {1'b0, inv_prox_q};
      end
      OP_HORNER_MUL: begin
        mul_a = {3'b0, r_q[15:0], 14'b0};
        mul_b = {2'b0, s_q};
      end
      OP_HORNER_DIV: begin
        mul_a = {3'b0, hq};
        mul_b = {1'b0, RECIP_M[cmd_i.k]};
      end
      default: mul_en = 1'b0;
    endcase
  end

  // Transform accumulation: each product is floored back to Q16.16.
  assign acc_base = (cmd_i.col == 2'd0) ? 52'(pose_q[tidx]) : acc_q;
  assign acc_d    = acc_base + 52'($signed(prod_q[65:16]));

  always_comb begin
    if (acc_d > 52'sd2147483647) begin
      sat_d = 32'sh7fff_ffff;
    end else if (acc_d < -52'sd2147483648) begin
      sat_d = 32'sh8000_0000;
    end else begin
      sat_d = acc_d[31:0];
    end
  end

  assign sh_rnd   = 6'd13 + {1'b0, n_q};
  assign sh_out   = 6'd14 + {1'b0, n_q};
  assign prox_sum = {4'b0, s_q} + (35'd1 << sh_rnd);

  assign ax_sh  = ax_q >>> cmd_i.step;
  assign ay_sh  = ay_q >>> cmd_i.step;
  assign ex_sh  = ex_q >>> cmd_i.step;
  assign ey_sh  = ey_q >>> cmd_i.step;
  assign atan_s = {3'b0, ATAN_TAB[cmd_i.step]};
  assign az_r   = (aang_q + 20'sd4) >>> 3;
  assign el_r   = (eang_q + 20'sd4) >>> 3;

  assign stat_o.qualify  = act_q && (mass_q >= min_mass_q) &&
                           (emit_q < CNT_W'(MAX_SOURCES));
  assign stat_o.depth_ok = (zc_q > DEPTH_FLOOR) && (zc_q[30:0] <= max_depth_q);
  assign stat_o.big      = big_q;
  assign stat_o.rem_ge   = (r_q >= LN2_Q16);

  // Configuration, pose store and frame count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_mass_q  <= 32'd65536;
      max_depth_q <= 31'd655360;
      inv_prox_q  <= 32'd52429;
      inv_ref_q   <= 32'd6554;
      emit_q      <= '0;
      for (int i = 0; i < 12; i++) begin
        pose_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_MIN_MASS:       min_mass_q  <= cfg_wdata_i;
          CFG_MAX_DEPTH:      max_depth_q <= cfg_wdata_i[30:0];
          CFG_INV_PROX_DECAY: inv_prox_q  <= cfg_wdata_i;
          CFG_INV_REF_MASS:   inv_ref_q   <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (cmd_i.op == OP_POSE_WR && pose_index_i < 4'd12) begin
        pose_q[pose_index_i] <= pose_value_i;
      end
      if (cmd_i.op == OP_EMIT) begin
        emit_q <= emit_q + CNT_W'(1);
      end else if (cmd_i.op == OP_FINISH && last_q) begin
        emit_q <= '0;
      end
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (mul_en) begin
      prod_q <= mul_a * mul_b;
    end
    case (cmd_i.op)
      OP_LOAD: begin
        act_q  <= cluster_active_i;
        mass_q <= cluster_mass_i;
        cx_q   <= cluster_x_i;
        cy_q   <= cluster_y_i;
        cz_q   <= cluster_z_i;
        last_q <= last_cluster_i;
      end
      OP_XF_ACC: begin
        acc_q <= acc_d;
        if (cmd_i.col == 2'd2) begin
          case (cmd_i.row)
            2'd0:    xc_q <= sat_d;
            2'd1:    yc_q <= sat_d;
            default: zc_q <= sat_d;
          endcase
        end
      end
      OP_PROX_MUL: begin
        conf_q <= (a_val > 48'(ONE_Q16)) ? ONE_Q16 : a_val[16:0];
      end
      OP_PROX_A: begin
        big_q <= (a_val >= PROX_LIMIT);
        r_q   <= a_val[19:0];
        n_q   <= '0;
      end
      OP_DIV_STEP: begin
        if (stat_o.rem_ge) begin
          r_q <= r_q - LN2_Q16;
          n_q <= n_q + 5'd1;
        end else begin
          s_q <= ONE_Q30;
        end
      end
      OP_HORNER_DIV: begin
        if (k_pow2(cmd_i.k)) begin
          s_q <= ONE_Q30 - {1'b0, hq >> k_log2(cmd_i.k)};
        end
      end
      OP_HORNER_SUB: begin
        s_q <= ONE_Q30 - {1'b0, prod_q[62:33]};
      end
      OP_PROX_FIN: begin
        prox_q <= big_q ? 17'd0 : 17'(prox_sum >> sh_out);
      end
      OP_CORDIC_INIT: begin
        ax_q   <= 36'(zc_q);
        ay_q   <= 36'(xc_q);
        ex_q   <= 36'(zc_q);
        ey_q   <= -36'(yc_q);
        aang_q <= '0;
        eang_q <= '0;
      end
      OP_CORDIC_STEP: begin
        if (ay_q > 36'sd0) begin
          ax_q   <= ax_q + ay_sh;
          ay_q   <= ay_q - ax_sh;
          aang_q <= aang_q + atan_s;
        end else begin
          ax_q   <= ax_q - ay_sh;
          ay_q   <= ay_q + ax_sh;
          aang_q <= aang_q - atan_s;
        end
        if (ey_q > 36'sd0) begin
          ex_q   <= ex_q + ey_sh;
          ey_q   <= ey_q - ex_sh;
          eang_q <= eang_q + atan_s;
        end else begin
          ex_q   <= ex_q - ey_sh;
          ey_q   <= ey_q + ex_sh;
          eang_q <= eang_q - atan_s;
        end
      end
      OP_EMIT: begin
        azimuth_o     <= az_r[15:0];
        elevation_o   <= el_r[15:0];
        proximity_o   <= prox_q;
        confidence_o  <= conf_q;
        source_slot_o <= 3'(emit_q);
      end
      default: ;
    endcase
  end

endmodule

@@ hdl/otas_ctrl.sv @@
// ---------------------------------------------------------------------------
// Obstacle to audio source controller
// Sequences one transaction at a time through the datapath.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module otas_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            func_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  input  otas_pkg::stat_t stat_i,
  output otas_pkg::cmd_t  cmd_o
);
  import otas_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_XMUL, S_XACC, S_DEPTH, S_CMUL, S_PMUL, S_PA, S_DIV,
    S_H1, S_H2, S_H3, S_PFIN, S_CINIT, S_CORD, S_EMIT, S_FIN
  } state_e;

  state_e state_q;
  logic [1:0] row_q, col_q;
  logic [3:0] k_q, step_q;
  logic out_valid_q;
  logic out_free;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_free    = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o.row  = row_q;
    cmd_o.col  = col_q;
    cmd_o.k    = k_q;
    cmd_o.step = step_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.op = func_i ? OP_LOAD : OP_POSE_WR;
        end else begin
          cmd_o.op = OP_IDLE;
        end
      end
      S_XMUL:  cmd_o.op = OP_XF_MUL;
      S_XACC:  cmd_o.op = OP_XF_ACC;
      S_CMUL:  cmd_o.op = OP_CONF_MUL;
      S_PMUL:  cmd_o.op = OP_PROX_MUL;
      S_PA:    cmd_o.op = OP_PROX_A;
      S_DIV:   cmd_o.op = stat_i.big ? OP_IDLE : OP_DIV_STEP;
      S_H1:    cmd_o.op = OP_HORNER_MUL;
      S_H2:    cmd_o.op = OP_HORNER_DIV;
      S_H3:    cmd_o.op = OP_HORNER_SUB;
      S_PFIN:  cmd_o.op = OP_PROX_FIN;
      S_CINIT: cmd_o.op = OP_CORDIC_INIT;
      S_CORD:  cmd_o.op = OP_CORDIC_STEP;
      S_EMIT:  cmd_o.op = out_free ? OP_EMIT : OP_IDLE;
      S_FIN:   cmd_o.op = OP_FINISH;
      default: cmd_o.op = OP_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      row_q       <= '0;
      col_q       <= '0;
      k_q         <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (state_q == S_EMIT && out_free) begin
        out_valid_q <= 1'b1;
      end else if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i && func_i) begin
            state_q <= S_CHECK;
          end
        end
        S_CHECK: begin
          row_q   <= '0;
          col_q   <= '0;
          state_q <= stat_i.qualify ? S_XMUL : S_FIN;
        end
        S_XMUL: state_q <= S_XACC;
        S_XACC: begin
          if (col_q != 2'd2) begin
            col_q   <= col_q + 2'd1;
            state_q <= S_XMUL;
          end else if (row_q != 2'd2) begin
            col_q   <= '0;
            row_q   <= row_q + 2'd1;
            state_q <= S_XMUL;
          end else begin
            state_q <= S_DEPTH;
          end
        end
        S_DEPTH: state_q <= stat_i.depth_ok ? S_CMUL : S_FIN;
        S_CMUL:  state_q <= S_PMUL;
        S_PMUL:  state_q <= S_PA;
        S_PA:    state_q <= S_DIV;
        S_DIV: begin
          if (stat_i.big) begin
            state_q <= S_PFIN;
          end else if (!stat_i.rem_ge) begin
            k_q     <= 4'd8;
            state_q <= S_H1;
          end
        end
        S_H1: state_q <= S_H2;
        S_H2: begin
          if (!k_pow2(k_q)) begin
            state_q <= S_H3;
          end else if (k_q == 4'd1) begin
            state_q <= S_PFIN;
          end else begin
            k_q     <= k_q - 4'd1;
            state_q <= S_H1;
          end
        end
        S_H3: begin
          k_q     <= k_q - 4'd1;
          state_q <= S_H1;
        end
        S_PFIN: state_q <= S_CINIT;
        S_CINIT: begin
          step_q  <= '0;
          state_q <= S_CORD;
        end
        S_CORD: begin
          step_q <= step_q + 4'd1;
          if (step_q == 4'(CORDIC_STEPS - 1)) begin
            state_q <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (out_free) begin
            state_q <= S_FIN;
          end
        end
        S_FIN:   state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/obstacle_to_audio_source_top.sv @@
// ---------------------------------------------------------------------------
// Obstacle to audio source, top level
// Turns world-frame obstacle clusters into per-frame audio source parameters.
// ---------------------------------------------------------------------------
// A pose word transaction (func = 0) is written into the pose store in the
// cycle it is accepted, so pose words stream at one per cycle while the block
// is idle. A cluster transaction (func = 1) is worked on alone: the block
// moves the centroid into the camera frame with one shared 33 by 33 bit
// multiplier (nine multiply and accumulate pairs), checks the depth window,
// forms confidence and the proximity exponent, reduces the exponent by ln(2)
// one subtraction per cycle, evaluates exp() by an eight-term Horner scheme,
// and runs 16 CORDIC vectoring steps for azimuth and elevation side by side.
// When the exponent is so large that the proximity is zero the Horner pass is
// skipped. A cluster that fails the mass, count or depth check gives no
// result. The result sits in an output register, so the next transaction is
// accepted while an earlier result still waits to be taken; a later result
// waits for the register to be free, which adds the stall to its latency.
// Configuration writes take effect at once and must only be issued while the
// block is idle.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module obstacle_to_audio_source_top #(
  parameter int MAX_SOURCES = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port.
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  // Input transaction channel.
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               func_i,
  input  logic [3:0]         pose_index_i,
  input  logic signed [31:0] pose_value_i,
  input  logic               cluster_active_i,
  input  logic [31:0]        cluster_mass_i,
  input  logic signed [31:0] cluster_x_i,
  input  logic signed [31:0] cluster_y_i,
  input  logic signed [31:0] cluster_z_i,
  input  logic               last_cluster_i,
  // Result transaction channel.
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] azimuth_o,
  output logic signed [15:0] elevation_o,
  output logic [16:0]        proximity_o,
  output logic [16:0]        confidence_o,
  output logic [2:0]         source_slot_o
);
  import otas_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // The controller owns the handshake and the sequence of datapath steps.
  otas_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .func_i      (func_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // The datapath holds the pose store, configuration and all arithmetic.
  otas_dp #(
    .MAX_SOURCES (MAX_SOURCES)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_addr_i       (cfg_addr_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .pose_index_i     (pose_index_i),
    .pose_value_i     (pose_value_i),
    .cluster_active_i (cluster_active_i),
    .cluster_mass_i   (cluster_mass_i),
    .cluster_x_i      (cluster_x_i),
    .cluster_y_i      (cluster_y_i),
    .cluster_z_i      (cluster_z_i),
    .last_cluster_i   (last_cluster_i),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .azimuth_o        (azimuth_o),
    .elevation_o      (elevation_o),
    .proximity_o      (proximity_o),
    .confidence_o     (confidence_o),
    .source_slot_o    (source_slot_o)
  );

  // A waiting result stays valid and unchanged until it is taken.
  `ASSERT_NEXT(a_result_held, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(source_slot_o))
  // A new result can only appear while a cluster is being worked on.
  `ASSERT_IMPLIES(a_rise_while_busy, clk_i, rst_ni, $rose(out_valid_o), $past(!in_ready_o))
  // Proximity and confidence never exceed one.
  `ASSERT_IMPLIES(a_unit_range, clk_i, rst_ni, out_valid_o, (proximity_o <= 17'd65536) && (confidence_o <= 17'd65536))
  // Angles stay within plus or minus pi (Q3.13).
  `ASSERT_IMPLIES(a_angle_range, clk_i, rst_ni, out_valid_o, (azimuth_o >= -16'sd25736) && (azimuth_o <= 16'sd25736) && (elevation_o >= -16'sd25736) && (elevation_o <= 16'sd25736))

endmodule

@@ sim/tb_top.sv @@
// ---------------------------------------------------------------------------
// Obstacle to audio source testbench
// Drives pose words and cluster transactions with random gaps and stalls, and
// checks every result against a built-in fixed-point predictor.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
module tb_top;
  import otas_pkg::*;

  localparam int NSRC = 8;
  localparam int CYCLE_LIMIT = 1500000;

  // Field layout of one input transaction.
  typedef struct {
    logic        func;
    logic [3:0]  pidx;
    logic [31:0] pval;
    logic        active;
    logic [31:0] mass;
    logic [31:0] cx, cy, cz;
    logic        last;
  } item_t;

  // Field layout of one audio source result.
  typedef struct {
    logic [15:0] az, el;
    logic [16:0] prox, conf;
    logic [2:0]  slot;
  } src_t;

  // A directed row: the transaction, plus an optional typed-in result.
  typedef struct {
    item_t it;
    logic  has_fixed;
    src_t  fixed;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_addr = '0;
  logic [31:0] cfg_wdata = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic func = 1'b0;
  logic [3:0] pidx = '0;
  logic signed [31:0] pval = '0;
  logic active = 1'b0;
  logic [31:0] mass = '0;
  logic signed [31:0] cx = '0, cy = '0, cz = '0;
  logic last = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [15:0] az, el;
  logic [16:0] prox, conf;
  logic [2:0] slot;

  // Predictor state: pose store, per-frame source count, register copies.
  logic signed [31:0] pose_m [12];
  int unsigned src_count;
  logic [31:0] min_mass_m, inv_decay_m, inv_ref_m;
  logic [30:0] max_depth_m;

  src_t expected_sources[$];
  int errors = 0;
  int cycles = 0;
  bit stalls_on = 1'b1;

  obstacle_to_audio_source_top #(.MAX_SOURCES(NSRC)) dut (
    .clk_i(clk), .rst_ni(rst_n),
    .cfg_we_i(cfg_we), .cfg_addr_i(cfg_addr), .cfg_wdata_i(cfg_wdata),
    .in_valid_i(in_valid), .in_ready_o(in_ready),
    .func_i(func), .pose_index_i(pidx), .pose_value_i(pval),
    .cluster_active_i(active), .cluster_mass_i(mass),
    .cluster_x_i(cx), .cluster_y_i(cy), .cluster_z_i(cz),
    .last_cluster_i(last),
    .out_valid_o(out_valid), .out_ready_i(out_ready),
    .azimuth_o(az), .elevation_o(el), .proximity_o(prox),
    .confidence_o(conf), .source_slot_o(slot)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // The cycle counter doubles as the watchdog.
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    errors++;
    $display("mismatch at cycle %0d: %s", cycles, what);
  endtask

  // Floor division by 2^s of a signed value; >>> already floors.
  function automatic longint fshift(input longint v, input int s);
    return v >>> s;
  endfunction

  // One row of the camera-frame transform, saturated to 32 signed bits.
  function automatic logic signed [31:0] cam_row(input int r, input logic signed [31:0] x,
                                                 input logic signed [31:0] y,
                                                 input logic signed [31:0] z);
    longint acc;
    acc = longint'(pose_m[9 + r]);
    acc += fshift(longint'(pose_m[r*3]) * longint'(x), 16);
    acc += fshift(longint'(pose_m[r*3+1]) * longint'(y), 16);
    acc += fshift(longint'(pose_m[r*3+2]) * longint'(z), 16);
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    return acc[31:0];
  endfunction

  // Vectoring CORDIC atan2(y, x) for x > 0, Q3.13 result.
  function automatic logic [15:0] cordic_angle(input longint y, input longint x);
    longint ang, dx, dy;
    ang = 0;
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = fshift(y, i);
      dy = fshift(x, i);
      if (y > 0) begin
        x += dx; y -= dy; ang += longint'(ATAN_TAB[i]);
      end else begin
        x -= dx; y += dy; ang -= longint'(ATAN_TAB[i]);
      end
    end
    return 16'(fshift(ang + 4, 3));
  endfunction

  // exp(-z * inv_decay) in Q1.16 by range reduction and a Horner series.
  function automatic logic [16:0] closeness(input logic [31:0] z);
    longint unsigned a, n, r, s;
    a = (longint'(z) * longint'(inv_decay_m)) >> 16;
    n = a / 45426;
    r = (a - n * 45426) << 14;
    s = 64'd1 << 30;
    if (n > 20) return '0;
    for (int k = 8; k >= 1; k--) s = (64'd1 << 30) - (((r * s) >> 30) / k);
    return 17'((s + (64'd1 << (13 + n))) >> (14 + n));
  endfunction

  // Updates the predictor for one accepted transaction and queues any result.
  task automatic predict_sources(input item_t it);
    logic signed [31:0] xc, yc, zc;
    longint unsigned c;
    src_t s;
    if (!it.func) begin
      if (it.pidx < 12) pose_m[it.pidx] = it.pval;
      return;
    end
    if (it.active && it.mass >= min_mass_m && src_count < NSRC) begin
      xc = cam_row(0, it.cx, it.cy, it.cz);
      yc = cam_row(1, it.cx, it.cy, it.cz);
      zc = cam_row(2, it.cx, it.cy, it.cz);
      if (zc > DEPTH_FLOOR && zc <= $signed({1'b0, max_depth_m})) begin
        c = (longint'(it.mass) * longint'(inv_ref_m)) >> 16;
        if (c > 65536) c = 65536;
        s.az = cordic_angle(longint'(xc), longint'(zc));
        s.el = cordic_angle(-longint'(yc), longint'(zc));
        s.prox = closeness(zc);
        s.conf = 17'(c);
        s.slot = 3'(src_count);
        expected_sources.push_back(s);
        src_count++;
      end
    end
    if (it.last) src_count = 0;
  endtask

  // Result side: random stalls, field-by-field compare against the oldest result.
  always @(posedge clk) begin
    src_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_sources.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = expected_sources.pop_front();
        if (az !== e.az) report_mismatch($sformatf("azimuth %0d exp %0d", az, $signed(e.az)));
        if (el !== e.el) report_mismatch($sformatf("elevation %0d exp %0d", el, $signed(e.el)));
        if (prox !== e.prox) report_mismatch($sformatf("proximity %0d exp %0d", prox, e.prox));
        if (conf !== e.conf) report_mismatch($sformatf("confidence %0d exp %0d", conf, e.conf));
        if (slot !== e.slot) report_mismatch($sformatf("slot %0d exp %0d", slot, e.slot));
      end
    end
    if (!stalls_on || $urandom_range(99) < 60) out_ready <= 1'b1;
    else if ($urandom_range(99) < 5) out_ready <= 1'b0;
    else out_ready <= ($urandom_range(3) != 0);
  end

  // One register write, then a pause with the write enable low so write enables never pile up.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
    cfg_we <= 1'b1; cfg_addr <= idx; cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_MIN_MASS:       min_mass_m = v;
      CFG_MAX_DEPTH:      max_depth_m = v[30:0];
      CFG_INV_PROX_DECAY: inv_decay_m = v;
      default:            inv_ref_m = v;
    endcase
    @(posedge clk);
  endtask

  // Random pause before a transaction: mostly none, sometimes short, rarely long.
  task automatic sender_gap();
    int p;
    p = $urandom_range(99);
    if (!stalls_on || p < 55) return;
    in_valid <= 1'b0;
    repeat (p < 92 ? $urandom_range(1, 3) : $urandom_range(10, 120)) @(posedge clk);
  endtask

  // Presents one transaction and holds it until accepted. Valid stays high
  // after acceptance; the next transaction or a gap decides what follows.
  task automatic send_item(input item_t it);
    sender_gap();
    in_valid <= 1'b1;
    func <= it.func; pidx <= it.pidx; pval <= it.pval;
    active <= it.active; mass <= it.mass;
    cx <= it.cx; cy <= it.cy; cz <= it.cz; last <= it.last;
    do @(posedge clk); while (!in_ready);
    predict_sources(it);
  endtask

  // Waits until all results are out, plus the worst in-flight cluster time.
  task automatic drain();
    in_valid <= 1'b0;
    while (expected_sources.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  function automatic item_t pose_word(input int idx, input logic [31:0] v);
    item_t it;
    it = '{default: '0};
    it.pidx = 4'(idx); it.pval = v;
    return it;
  endfunction

  function automatic item_t cluster(input logic [31:0] m, input logic [31:0] x,
                                    input logic [31:0] y, input logic [31:0] z,
                                    input logic a, input logic l);
    item_t it;
    it = '{default: '0};
    it.func = 1'b1; it.active = a; it.mass = m;
    it.cx = x; it.cy = y; it.cz = z; it.last = l;
    return it;
  endfunction

  // Loads a pose: mostly near-identity rotations with a forward offset, and
  // now and then fully random words to reach saturation.
  task automatic send_pose();
    logic [31:0] w;
    for (int i = 0; i < 12; i++) begin
      if ($urandom_range(9) == 0) w = $urandom;
      else if (i < 9) w = ((i % 4) == 0) ? 32'h10000 + $urandom_range(0, 8000) - 4000
                                         : 32'($signed($urandom_range(0, 24000)) - 12000);
      else w = (i == 11) ? $urandom_range(0, 300000) : 32'($signed($urandom_range(0, 200000)) - 100000);
      send_item(pose_word(i, w));
    end
  endtask

  function automatic item_t rand_cluster(input logic l);
    logic [31:0] m, x, y, z;
    m = ($urandom_range(9) == 0) ? $urandom : $urandom_range(0, 2000000);
    x = ($urandom_range(9) == 0) ? $urandom : 32'($signed($urandom_range(0, 400000)) - 200000);
    y = ($urandom_range(9) == 0) ? $urandom : 32'($signed($urandom_range(0, 400000)) - 200000);
    z = ($urandom_range(9) == 0) ? $urandom : 32'($signed($urandom_range(0, 900000)) - 100000);
    return cluster(m, x, y, z, $urandom_range(7) != 0, l);
  endfunction

  row_t rows[$];
  src_t fx;

  initial begin
    int sent;
    int n0;
    item_t it;
    for (int i = 0; i < 12; i++) pose_m[i] = '0;
    src_count = 0;
    min_mass_m = 32'd65536; max_depth_m = 31'd655360;
    inv_decay_m = 32'd52429; inv_ref_m = 32'd6554;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table. With a zero pose every depth is zero, so clusters drop.
    rows.push_back('{cluster(32'hFFFF_FFFF, 1, 2, 3, 1, 0), 0, fx});
    rows.push_back('{pose_word(12, 32'hFFFF_FFFF), 0, fx});
    rows.push_back('{pose_word(15, 32'h1234_5678), 0, fx});
    rows.push_back('{pose_word(0, 32'h10000), 0, fx});
    rows.push_back('{pose_word(4, 32'h10000), 0, fx});
    rows.push_back('{pose_word(8, 32'h10000), 0, fx});
    // Point straight ahead, at the floor depth and just above it.
    fx = '{16'd0, 16'd0, 17'd0, 17'd6554, 3'd0};
    rows.push_back('{cluster(32'h10000, 0, 0, 655, 1, 0), 0, fx});
    rows.push_back('{cluster(32'h10000, 0, 0, 656, 1, 0), 0, fx});
    rows.push_back('{cluster(32'hFFFF_FFFF, 0, 0, 655360, 1, 0), 0, fx});
    rows.push_back('{cluster(32'hFFFF, 0, 0, 65536, 1, 0), 0, fx});
    rows.push_back('{cluster(32'h10000, 0, 0, 655361, 1, 0), 0, fx});
    rows.push_back('{cluster(32'h10000, 32'h7FFF_FFFF, 32'h8000_0000, 65536, 1, 0), 0, fx});
    rows.push_back('{cluster(32'h10000, 32'h8000_0000, 32'h7FFF_FFFF, 65536, 1, 0), 0, fx});
    rows.push_back('{cluster(32'h20000, 0, 0, 32'h8000_0000, 1, 0), 0, fx});
    rows.push_back('{cluster(32'h20000, 0, 0, 100000, 0, 1), 0, fx});
    for (int i = 0; i < 10; i++)
      rows.push_back('{cluster(32'h30000, 1000*i, -500*i, 70000, 1, i == 9), 0, fx});
    foreach (rows[r]) begin
      if (rows[r].has_fixed) begin
        n0 = expected_sources.size();
        send_item(rows[r].it);
        if (expected_sources.size() != n0 + 1) begin
          report_mismatch("directed row gave no result");
        end else begin
          void'(expected_sources.pop_back());
          expected_sources.push_back(rows[r].fixed);
        end
      end else begin
        send_item(rows[r].it);
      end
    end
    drain();

    // Random phases, each with its own register setting; extremes included.
    sent = 0;
    for (int ph = 0; ph < 6; ph++) begin
      stalls_on = (ph != 2);
      case (ph)
        0: begin
          write_reg(CFG_MIN_MASS, 0); write_reg(CFG_MAX_DEPTH, 32'h7FFF_FFFF);
          write_reg(CFG_INV_PROX_DECAY, 0); write_reg(CFG_INV_REF_MASS, 32'hFFFF_FFFF);
        end
        1: begin
          write_reg(CFG_MIN_MASS, 32'hFFFF_FFFF); write_reg(CFG_MAX_DEPTH, 0);
          write_reg(CFG_INV_PROX_DECAY, 32'hFFFF_FFFF); write_reg(CFG_INV_REF_MASS, 0);
        end
        default: begin
          write_reg(CFG_MIN_MASS, $urandom_range(0, 200000));
          write_reg(CFG_MAX_DEPTH, $urandom_range(300000, 900000) | (ph == 5 ? 32'h8000_0000 : 0));
          write_reg(CFG_INV_PROX_DECAY, $urandom_range(0, 400000));
          write_reg(CFG_INV_REF_MASS, $urandom);
        end
      endcase
      for (int f = 0; f < 5; f++) begin
        if (ph == 1 && f >= 2) break;
        send_pose();
        for (int c = 0, n = $urandom_range(3, 14); c < n; c++) begin
          send_item(rand_cluster(c == n - 1));
          sent++;
        end
        if ($urandom_range(3) == 0) begin
          it = pose_word($urandom_range(12, 15), $urandom);
          it.last = 1'b1;
          send_item(it);
        end
      end
      drain();
    end

    if (errors == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end

endmodule
